### src/bkm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bkm_pkg
// Types, register indexes, reset values and sine table entry function for
// the binary keying modulator.
// ----------------------------------------------------------------------------
package bkm_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int SINE_W     = 15;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE         = 3'd0,
        CFG_PHASE_STEP_A = 3'd1,
        CFG_PHASE_STEP_B = 3'd2,
        CFG_AMP_ZERO     = 3'd3,
        CFG_AMP_ONE      = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        MODE_ASK = 2'd0,
        MODE_PSK = 2'd1,
        MODE_FSK = 2'd2
    } t_mode;

    localparam logic [15:0] AMP_ZERO_RST = 16'd16384;
    localparam logic [15:0] AMP_ONE_RST  = 16'd32768;

    typedef struct packed {
        logic data_bit;
        logic last_sample;
    } t_in;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_out;
    } t_out;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint POLY_0  = 64'sd1686629713;
    localparam longint POLY_1  = -64'sd693598668;
    localparam longint POLY_2  = 64'sd85569306;
    localparam longint POLY_3  = -64'sd5026994;
    localparam longint POLY_4  = 64'sd172273;
    localparam longint SINE_MAX = 64'sd32767;

    function automatic longint mul_q30(longint a, longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // Quarter-wave entry k: sin(pi/2 * (k+0.5)/2^addr_bits), Q30 odd polynomial
    function automatic logic [SINE_W-1:0] sine_entry(int addr_bits, int k);
        longint x;
        longint x2;
        longint p;
        longint s;
        longint v;
        x  = longint'(2 * k + 1) <<< (29 - addr_bits);
        x2 = mul_q30(x, x);
        p  = POLY_4;
        p  = POLY_3 + mul_q30(p, x2);
        p  = POLY_2 + mul_q30(p, x2);
        p  = POLY_1 + mul_q30(p, x2);
        p  = POLY_0 + mul_q30(p, x2);
        s  = mul_q30(p, x);
        if (s < 0) begin
            s = 0;
        end
        v = (s * SINE_MAX + (Q30_ONE / 2)) / Q30_ONE;
        if (v > SINE_MAX) begin
            v = SINE_MAX;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage
`default_nettype wire

### src/binary_keying_modulator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_keying_modulator_top
// ASK / PSK / FSK carrier modulator: one signed Q1.15 sample per request.
// ----------------------------------------------------------------------------
// Requests enter and samples leave one per clock unless stalled; each passes
// the fold, ROM, product and output registers. Both phase accumulators advance
// when a request is taken and clear after a request marked last. The sine
// comes from a quarter-wave ROM of 2^SINE_ADDR_BITS entries with registered
// read data; the ASK product has its own register before saturation. The user
// writes config via a plain write port only while idle; nothing enforces it.
module binary_keying_modulator_top #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [bkm_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [bkm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  bkm_pkg::t_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output bkm_pkg::t_out                       o_out_data
);

    localparam int QTAB_SIZE = 1 << SINE_ADDR_BITS;
    localparam int PROD_W    = 33;
    localparam logic signed [PROD_W-1:0] SAT_HI = 33'sd32767;
    localparam logic signed [PROD_W-1:0] SAT_LO = -33'sd32768;

    bkm_pkg::t_mode         r_mode;
    logic [31:0]            r_step_a;
    logic [31:0]            r_step_b;
    logic [15:0]            r_amp_zero;
    logic [15:0]            r_amp_one;

    logic [PHASE_BITS-1:0]  r_phase_a;
    logic [PHASE_BITS-1:0]  r_phase_b;

    logic [bkm_pkg::SINE_W-1:0] w_rom [QTAB_SIZE];

    logic                       r_s1_valid;
    logic [SINE_ADDR_BITS-1:0]  r_s1_idx;
    logic                       r_s1_neg;
    bkm_pkg::t_mode             r_s1_mode;
    logic [15:0]                r_s1_amp;
    logic                       r_s1_last;

    logic                       r_s2_valid;
    logic [bkm_pkg::SINE_W-1:0] r_s2_mag;
    logic                       r_s2_neg;
    bkm_pkg::t_mode             r_s2_mode;
    logic [15:0]                r_s2_amp;
    logic                       r_s2_last;

    logic                       r_s3_valid;
    logic signed [PROD_W-1:0]   r_s3_prod;
    logic signed [15:0]         r_s3_sine;
    bkm_pkg::t_mode             r_s3_mode;
    logic                       r_s3_last;

    logic                       r_out_valid;
    bkm_pkg::t_out              r_out_data;
    bkm_pkg::t_out              n_out_data;

    logic                       w_rdy_out;
    logic                       w_rdy_s3;
    logic                       w_rdy_s2;
    logic                       w_rdy_s1;
    logic                       w_accept;

    logic [PHASE_BITS-1:0]      w_phase;
    logic [SINE_ADDR_BITS+1:0]  w_addr;
    logic                       w_psk_flip;
    logic signed [15:0]         w_sine;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_scaled;
    logic signed [15:0]         w_sat;

    generate
        for (genvar k = 0; k < QTAB_SIZE; k++) begin : g_rom
            localparam logic [bkm_pkg::SINE_W-1:0] ENTRY =
                bkm_pkg::sine_entry(SINE_ADDR_BITS, k);
            assign w_rom[k] = ENTRY;
        end
    endgenerate

    assign w_rdy_out  = !r_out_valid || !i_out_stall;
    assign w_rdy_s3   = !r_s3_valid || w_rdy_out;
    assign w_rdy_s2   = !r_s2_valid || w_rdy_s3;
    assign w_rdy_s1   = !r_s1_valid || w_rdy_s2;
    assign o_in_stall = !w_rdy_s1;
    assign w_accept   = i_in_valid && w_rdy_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= bkm_pkg::MODE_ASK;
            r_step_a   <= '0;
            r_step_b   <= '0;
            r_amp_zero <= bkm_pkg::AMP_ZERO_RST;
            r_amp_one  <= bkm_pkg::AMP_ONE_RST;
        end else if (i_cfg_we) begin
            case (bkm_pkg::t_cfg_reg'(i_cfg_addr))
                bkm_pkg::CFG_MODE:         r_mode     <= bkm_pkg::t_mode'(i_cfg_data[1:0]);
                bkm_pkg::CFG_PHASE_STEP_A: r_step_a   <= i_cfg_data;
                bkm_pkg::CFG_PHASE_STEP_B: r_step_b   <= i_cfg_data;
                bkm_pkg::CFG_AMP_ZERO:     r_amp_zero <= i_cfg_data[15:0];
                bkm_pkg::CFG_AMP_ONE:      r_amp_one  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_a <= '0;
            r_phase_b <= '0;
        end else if (w_accept) begin
            if (i_in_data.last_sample) begin
                r_phase_a <= '0;
                r_phase_b <= '0;
            end else begin
                r_phase_a <= r_phase_a + PHASE_BITS'(r_step_a);
                r_phase_b <= r_phase_b + PHASE_BITS'(r_step_b);
            end
        end
    end

    assign w_phase    = (r_mode == bkm_pkg::MODE_FSK && i_in_data.data_bit) ?
                        r_phase_b : r_phase_a;
    assign w_addr     = w_phase[PHASE_BITS-1 -: SINE_ADDR_BITS+2];
    assign w_psk_flip = (r_mode == bkm_pkg::MODE_PSK) && i_in_data.data_bit;

    // Stage 1: quadrant fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_rdy_s1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_s1) begin
            r_s1_idx  <= w_addr[SINE_ADDR_BITS-1:0] ^ {SINE_ADDR_BITS{w_addr[SINE_ADDR_BITS]}};
            r_s1_neg  <= w_addr[SINE_ADDR_BITS+1] ^ w_psk_flip;
            r_s1_mode <= r_mode;
            r_s1_amp  <= i_in_data.data_bit ? r_amp_one : r_amp_zero;
            r_s1_last <= i_in_data.last_sample;
        end
    end

    // Stage 2: ROM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_rdy_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_s2) begin
            r_s2_mag  <= w_rom[r_s1_idx];
            r_s2_neg  <= r_s1_neg;
            r_s2_mode <= r_s1_mode;
            r_s2_amp  <= r_s1_amp;
            r_s2_last <= r_s1_last;
        end
    end

    // Stage 3: sign and amplitude product
    assign w_sine = r_s2_neg ? -$signed({1'b0, r_s2_mag}) : $signed({1'b0, r_s2_mag});
    assign w_prod = $signed({1'b0, r_s2_amp}) * w_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_rdy_s3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_s3) begin
            r_s3_prod <= w_prod;
            r_s3_sine <= w_sine;
            r_s3_mode <= r_s2_mode;
            r_s3_last <= r_s2_last;
        end
    end

    // Output: floor shift, saturate, select by mode
    assign w_scaled = r_s3_prod >>> 15;

    always_comb begin
        if (w_scaled > SAT_HI) begin
            w_sat = 16'sh7FFF;
        end else if (w_scaled < SAT_LO) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_scaled[15:0];
        end
    end

    always_comb begin
        n_out_data.last_out = r_s3_last;
        case (r_s3_mode)
            bkm_pkg::MODE_ASK: n_out_data.sample = w_sat;
            bkm_pkg::MODE_PSK: n_out_data.sample = r_s3_sine;
            bkm_pkg::MODE_FSK: n_out_data.sample = r_s3_sine;
            default:           n_out_data.sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire
